@@ rtl/epmws_pkg.sv @@
// package for the end-pick max window sum block
// shared sizes, sequencer states and accumulator control type; no dependencies
package epmws_pkg;

    localparam int MAX_VALUES = 1024;
    localparam int VALUE_BITS = 16;

    localparam int TAKE_W   = 11;
    localparam int SUM_BITS = 26;

    localparam int ADDR_W = $clog2(MAX_VALUES);
    localparam int CNT_W  = $clog2(MAX_VALUES + 1);
    localparam int CMP_W  = (CNT_W > TAKE_W) ? CNT_W : TAKE_W;
    localparam int ACC_W  = VALUE_BITS + $clog2(MAX_VALUES);

    localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SUM_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_SWAP,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic vld;
        logic sub;
    } t_acc_ctl;

endpackage

@@ rtl/epmws_ram.sv @@
// generic one-write one-read ram with registered read data
// no dependencies
module epmws_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/epmws_acc.sv @@
// shared add/subtract unit with running sum and best-so-far registers
// depends on epmws_pkg
module epmws_acc
    import epmws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_acc_ctl              i_ctl,
    input  logic [VALUE_BITS-1:0] i_operand,
    output logic [ACC_W-1:0]      o_best
);

    logic [ACC_W-1:0] r_sum;
    logic [ACC_W-1:0] n_sum;
    logic [ACC_W-1:0] r_best;
    logic [ACC_W-1:0] n_best;
    logic             r_upd;
    logic [ACC_W-1:0] w_opnd;

    assign w_opnd = ACC_W'(i_operand);

    // one adder; best compare works on the registered sum in the cycle after each add
    always_comb begin
        n_sum  = r_sum;
        n_best = r_best;
        if (i_ctl.clr) begin
            n_sum  = '0;
            n_best = '0;
        end else begin
            if (i_ctl.vld) begin
                n_sum = i_ctl.sub ? (r_sum - w_opnd) : (r_sum + w_opnd);
            end
            if (r_upd && (r_sum > r_best)) begin
                n_best = r_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_best <= '0;
            r_upd  <= 1'b0;
        end else begin
            r_sum  <= n_sum;
            r_best <= n_best;
            r_upd  <= i_ctl.vld && !i_ctl.sub && !i_ctl.clr;
        end
    end

    assign o_best = r_best;

endmodule

@@ rtl/end_pick_max_window_sum_core.sv @@
// top level of the end-pick max window sum block
// depends on epmws_pkg, epmws_ram, epmws_acc
//
// channel     dir  handshake                     payload
// s_axis      in   s_axis_tvalid/s_axis_tready   tdata: card_value, tlast: is_last
// m_axis      out  m_axis_tvalid/m_axis_tready   tdata: best_sum, tuser: too_short
// cfg         in   i_cfg_we                      i_cfg_wdata: take_count
//
// loading takes one word per cycle; a word without tlast gives no result
// after the last word the search reads k words for the prefix sum (k = take_count),
// then two words per swap step, drains the pipeline and loads the output; the reads
// run one after another, set by the single read port of the store
// a short sequence or k of zero goes from the last word straight to the finishing step
// reset is synchronous, active low; no clearing pass, the store is written first
// s_axis_tready is low from the last word until the result enters the output
// register; the output register holds a result while m_axis_tready is low
module end_pick_max_window_sum_core
    import epmws_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config
    input  logic                   i_cfg_we,
    input  logic [TAKE_W-1:0]      i_cfg_wdata,    // take_count
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // card_value
    input  logic                   s_axis_tlast,   // is_last
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // best_sum, zero padded
    output logic                   m_axis_tuser    // too_short
);

    // state and counters
    t_state            r_state;
    t_state            n_state;
    logic [TAKE_W-1:0] r_take;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  n_k;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  n_n;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  n_idx;
    logic              r_half;
    logic              n_half;
    logic              r_drain;
    logic              n_drain;
    logic              r_short;
    logic              n_short;

    // read issue, aligned with the ram read data
    logic              r_iss_vld;
    logic              r_iss_sub;

    // output register
    logic              r_out_vld;
    logic [SUM_BITS-1:0] r_out_sum;
    logic              r_out_short;

    // control decode
    logic              w_accept;
    logic              w_room;
    logic [CNT_W-1:0]  w_n_final;
    logic              w_too_short;
    logic              w_k_zero;
    logic              w_idx_end;
    logic              w_out_free;
    logic              w_load_out;
    logic [CNT_W-1:0]  w_head;
    logic [CNT_W-1:0]  w_tail;

    logic              w_we;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [VALUE_BITS-1:0] w_rdata;
    t_acc_ctl          w_ctl;
    logic [ACC_W-1:0]  w_best;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_room      = (r_cnt < CNT_W'(MAX_VALUES));
    assign w_n_final   = w_room ? (r_cnt + CNT_W'(1)) : r_cnt;
    assign w_too_short = (CMP_W'(w_n_final) < CMP_W'(r_take));
    assign w_k_zero    = (r_take == '0);
    assign w_idx_end   = (r_idx == (r_k - CNT_W'(1)));
    assign w_out_free  = !r_out_vld || m_axis_tready;
    assign w_load_out  = (r_state == ST_DONE) && w_out_free;

    // innermost leading value out, outermost unused tail value in
    assign w_head = r_k - CNT_W'(1) - r_idx;
    assign w_tail = r_n - CNT_W'(1) - r_idx;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && s_axis_tlast) begin
                    n_state = (w_too_short || w_k_zero) ? ST_DONE : ST_SUM;
                end
            end
            ST_SUM: begin
                if (w_idx_end) begin
                    n_state = ST_SWAP;
                end
            end
            ST_SWAP: begin
                if (w_idx_end && r_half) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // outputs of the sequencer and counter updates
    always_comb begin
        s_axis_tready = 1'b0;
        w_we          = 1'b0;
        w_re          = 1'b0;
        w_raddr       = r_idx[ADDR_W-1:0];
        w_ctl         = '0;
        n_cnt         = r_cnt;
        n_k           = r_k;
        n_n           = r_n;
        n_idx         = r_idx;
        n_half        = r_half;
        n_drain       = r_drain;
        n_short       = r_short;
        case (r_state)
            ST_LOAD: begin
                s_axis_tready = 1'b1;
                if (w_accept) begin
                    // words beyond the store depth are dropped
                    w_we = w_room;
                    if (w_room) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    if (s_axis_tlast) begin
                        n_k       = CNT_W'(r_take);
                        n_n       = w_n_final;
                        n_idx     = '0;
                        n_half    = 1'b0;
                        n_short   = w_too_short;
                        w_ctl.clr = 1'b1;
                    end
                end
            end
            ST_SUM: begin
                w_re    = 1'b1;
                w_raddr = r_idx[ADDR_W-1:0];
                n_idx   = w_idx_end ? '0 : (r_idx + CNT_W'(1));
            end
            ST_SWAP: begin
                w_re    = 1'b1;
                w_raddr = r_half ? w_tail[ADDR_W-1:0] : w_head[ADDR_W-1:0];
                n_half  = !r_half;
                if (r_half) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                n_drain = 1'b0;
            end
            ST_DRAIN: begin
                n_drain = !r_drain;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_cnt = '0;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
        w_ctl.vld = r_iss_vld;
        w_ctl.sub = r_iss_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_take    <= TAKE_W'(1);
            r_cnt     <= '0;
            r_k       <= '0;
            r_n       <= '0;
            r_idx     <= '0;
            r_half    <= 1'b0;
            r_drain   <= 1'b0;
            r_short   <= 1'b0;
            r_iss_vld <= 1'b0;
            r_iss_sub <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_k       <= n_k;
            r_n       <= n_n;
            r_idx     <= n_idx;
            r_half    <= n_half;
            r_drain   <= n_drain;
            r_short   <= n_short;
            // the first read of each swap pair removes the head value
            r_iss_vld <= (r_state == ST_SUM) || (r_state == ST_SWAP);
            r_iss_sub <= (r_state == ST_SWAP) && !r_half;
            if (i_cfg_we) begin
                r_take <= i_cfg_wdata;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sum   <= r_short ? '0 : SUM_BITS'(w_best);
            r_out_short <= r_short;
        end
    end

    epmws_ram #(
        .DEPTH (MAX_VALUES),
        .WIDTH (VALUE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (s_axis_tdata[VALUE_BITS-1:0]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    epmws_acc u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_operand (w_rdata),
        .o_best    (w_best)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_sum);
    assign m_axis_tuser  = r_out_short;

    // read data only arrives for reads issued by the walk
    a_iss_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss_vld |-> ($past(r_state) == ST_SUM || $past(r_state) == ST_SWAP))
        else $error("accumulator fed outside the walk");

    // a new result is only produced by the finishing step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside the finishing step");

    // a short sequence always reports a zero sum
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_short) |-> (r_out_sum == '0))
        else $error("short sequence with nonzero sum");

    // the fill count never passes the store depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_VALUES))
        else $error("load count beyond store depth");

endmodule

@@ verif/tb.sv @@
// testbench for end_pick_max_window_sum_core
// depends on rtl/epmws_pkg.sv and rtl/end_pick_max_window_sum_core.sv
// directed card table, one long run past the store size, then random runs checked by a predictor
`timescale 1ns / 100ps

module tb;
    import epmws_pkg::*;

    // one row of the directed card table; take_count is written before the row when set_take
    typedef struct packed {
        logic                  set_take;
        logic [TAKE_W-1:0]     take;
        logic [VALUE_BITS-1:0] card;
        logic                  last;
        logic                  typed;      // sum and too_short below are the typed-in result
        logic [SUM_BITS-1:0]   sum;
        logic                  too_short;
    } t_card_row;

    typedef struct {
        logic [SUM_BITS-1:0] best_sum;
        logic                too_short;
    } t_pick_result;

    localparam int N_CARD_ROWS = 21;
    localparam int RANDOM_WORDS = 350;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [TAKE_W-1:0]      i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // card_value
    logic                   s_axis_tlast;   // is_last
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // best_sum, zero padded
    logic                   m_axis_tuser;   // too_short

    // predictor copy of the block: cards held so far and the take_count in force
    logic [VALUE_BITS-1:0] held_cards [MAX_VALUES];
    int                    held_cnt;
    logic [TAKE_W-1:0]     take_now;

    t_pick_result best_sum_q [$];   // results still to come, oldest first
    int           err_count;
    bit           no_idle;          // both sides run without gaps while set

    // rows with typed results: reset value of take_count, extremes, the short-sequence flag
    // and take_count of zero; the rest go through the predictor
    t_card_row card_plan [N_CARD_ROWS] = '{
        // take_count 1 from reset: a single card is its own best sum
        '{1'b0, 11'd0,    16'hFFFF, 1'b1, 1'b1, 26'd65535,  1'b0},
        '{1'b0, 11'd0,    16'h0000, 1'b1, 1'b1, 26'd0,      1'b0},
        // take_count 3, five cards, a swap from the tail pays off
        '{1'b1, 11'd3,    16'h0001, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'h0064, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'h0002, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'h0003, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'h0032, 1'b1, 1'b0, 26'd0,      1'b0},
        // sequence shorter than take_count
        '{1'b0, 11'd0,    16'h0007, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'h0008, 1'b1, 1'b1, 26'd0,      1'b1},
        // sequence exactly take_count long, all at the top value
        '{1'b0, 11'd0,    16'hFFFF, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'hFFFF, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'hFFFF, 1'b1, 1'b1, 26'd196605, 1'b0},
        // take_count of zero sums nothing
        '{1'b1, 11'd0,    16'h04D2, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'hBEEF, 1'b1, 1'b1, 26'd0,      1'b0},
        // all-ones take_count can never be met
        '{1'b1, 11'd2047, 16'h0005, 1'b1, 1'b1, 26'd0,      1'b1},
        // take_count 2 with alternating bit patterns
        '{1'b1, 11'd2,    16'h8000, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'h0001, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'h7FFE, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'hAAAA, 1'b0, 1'b0, 26'd0,      1'b0},
        '{1'b0, 11'd0,    16'h5555, 1'b1, 1'b0, 26'd0,      1'b0},
        // largest legal take_count against a single card
        '{1'b1, 11'd1024, 16'h1234, 1'b1, 1'b1, 26'd0,      1'b1}
    };

    end_pick_max_window_sum_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // best end-pick sum over the held cards: prefix of take_count cards, then trade the
    // innermost front card for the next card from the tail, keeping the maximum
    function automatic t_pick_result pick_best_ends();
        t_pick_result      res;
        longint unsigned   run;
        longint unsigned   best;
        int                n;
        int                k;
        n = held_cnt;
        k = int'(take_now);
        run = 0;
        best = 0;
        res.too_short = (n < k);
        if (!res.too_short && k > 0) begin
            for (int i = 0; i < k; i++)
                run += held_cards[i];
            best = run;
            for (int w = 0; w < k; w++) begin
                run = run - held_cards[k-1-w] + held_cards[n-1-w];
                if (run > best)
                    best = run;
            end
        end
        res.best_sum = res.too_short ? '0 : best[SUM_BITS-1:0];
        return res;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_card();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_BITS'($urandom_range(0, 15));
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // present one card after a random gap, none while no_idle is set, and wait for it to be
    // taken; on acceptance the predictor stores it and, on the last card, queues the result
    task automatic send_card(input logic [VALUE_BITS-1:0] card, input bit last, input bit typed,
                             input logic [SUM_BITS-1:0] t_sum, input bit t_short);
        int           gap;
        t_pick_result res;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(card);
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // cards past the store size are dropped and not counted
        if (held_cnt < MAX_VALUES) begin
            held_cards[held_cnt] = card;
            held_cnt++;
        end
        if (last) begin
            res = pick_best_ends();
            if (typed) begin
                res.best_sum  = t_sum;
                res.too_short = t_short;
            end
            best_sum_q.push_back(res);
            held_cnt = 0;
        end
    endtask

    // hold the sender off until every queued result has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (best_sum_q.size() != 0) @(posedge i_clk);
    endtask

    // take_count is only written with the block idle, after the search latency has passed
    task automatic write_take(input logic [TAKE_W-1:0] k);
        drain_results();
        repeat (3 * int'(take_now) + 4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        take_now = k;
    endtask

    // result checker: every accepted word is matched against the oldest expectation
    always @(posedge i_clk) begin
        t_pick_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (best_sum_q.size() == 0) begin
                report_mismatch("unexpected result word", m_axis_tdata, 0);
            end else begin
                want = best_sum_q.pop_front();
                if (m_axis_tdata !== OUT_TDATA_W'(want.best_sum))
                    report_mismatch("best_sum", m_axis_tdata, want.best_sum);
                if (m_axis_tuser !== want.too_short)
                    report_mismatch("too_short", m_axis_tuser, want.too_short);
            end
        end
    end

    // receiver: a random stall before each result word, none while no_idle is set
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // stimulus and end of run
    initial begin
        int                rand_words;
        int                run_len;
        int                n_runs;
        logic [TAKE_W-1:0] k;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        held_cnt  = 0;
        take_now  = 11'd1;
        err_count = 0;
        no_idle   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (card_plan[r]) begin
            if (card_plan[r].set_take)
                write_take(card_plan[r].take);
            send_card(card_plan[r].card, card_plan[r].last, card_plan[r].typed,
                      card_plan[r].sum, card_plan[r].too_short);
        end

        // full store at the top take_count; the two words past the store are dropped,
        // so the sum stays at its largest possible value
        write_take(11'd1024);
        no_idle = 1'b1;
        for (int i = 0; i < MAX_VALUES + 2; i++)
            send_card((i < MAX_VALUES) ? 16'hFFFF : 16'h0000, i == MAX_VALUES + 1,
                      i == MAX_VALUES + 1, 26'd67107840, 1'b0);

        // random phases: a take_count, then a few runs, most of them long enough to search
        rand_words = 0;
        while (rand_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 15))
                0:       k = '0;
                1:       k = TAKE_W'($urandom_range(1000, 2047));
                2, 3, 4: k = TAKE_W'($urandom_range(13, 40));
                default: k = TAKE_W'($urandom_range(1, 12));
            endcase
            write_take(k);
            no_idle = ($urandom_range(0, 3) == 0);
            n_runs = $urandom_range(1, 6);
            repeat (n_runs) begin
                // now and then let the output side empty out completely
                if ($urandom_range(0, 7) == 0)
                    drain_results();
                if (k > 64 || $urandom_range(0, 4) == 0)
                    run_len = $urandom_range(1, 20);
                else
                    run_len = $urandom_range(int'(k), int'(k) + 15);
                if (run_len < 1)
                    run_len = 1;
                for (int i = 0; i < run_len; i++)
                    send_card(pick_card(), i == run_len - 1, 1'b0, '0, 1'b0);
                rand_words += run_len;
            end
        end

        drain_results();
        repeat (3 * int'(take_now) + 8) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #8_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
